>>> rtl/core/ll1p_pkg.sv
// Shared types, constants and grammar tables for the LL(1) expression parser.
// Holds the symbol, column and production codes and the prediction table.
// No dependencies.
package ll1p_pkg;

  // Stack geometry; entry 0 always holds the end marker
  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = 6;

  // Token queue between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character bytes
  localparam logic [7:0] CH_A    = 8'h61;  // a
  localparam logic [7:0] CH_PLUS = 8'h2B;  // +
  localparam logic [7:0] CH_STAR = 8'h2A;  // *
  localparam logic [7:0] CH_LP   = 8'h28;  // (
  localparam logic [7:0] CH_RP   = 8'h29;  // )
  localparam logic [7:0] CH_END  = 8'h24;  // $

  typedef enum logic [3:0] {
    SY_END  = 4'd0,
    SY_E    = 4'd1,
    SY_A    = 4'd2,
    SY_T    = 4'd3,
    SY_B    = 4'd4,
    SY_F    = 4'd5,
    SY_TA   = 4'd6,   // terminal 'a'
    SY_PLUS = 4'd7,
    SY_STAR = 4'd8,
    SY_LP   = 4'd9,
    SY_RP   = 4'd10,
    SY_NONE = 4'd15
  } sym_t;

  typedef enum logic [2:0] {
    COL_A    = 3'd0,
    COL_PLUS = 3'd1,
    COL_STAR = 3'd2,
    COL_LP   = 3'd3,
    COL_RP   = 3'd4,
    COL_END  = 3'd5,
    COL_BAD  = 3'd6
  } col_t;

  typedef enum logic [1:0] {
    V_CONSUMED = 2'd0,
    V_ACCEPT   = 2'd1,
    V_REJECT   = 2'd2,
    V_IGNORED  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    P_ERR   = 3'd0,
    P_TA    = 3'd1,
    P_PTA   = 3'd2,
    P_FB    = 3'd3,
    P_SFB   = 3'd4,
    P_PAREN = 3'd5,
    P_EPS   = 3'd6,
    P_TOK   = 3'd7
  } prod_id_t;

  // Production body, symbols in push order (rightmost first)
  typedef struct packed {
    logic       err;
    logic [1:0] len;
    sym_t       s0;
    sym_t       s1;
    sym_t       s2;
  } prod_t;

  // Classified token travelling from front to engine
  typedef struct packed {
    logic valid;
    col_t col;
  } tok_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic busy;
    logic in_error;
  } eng_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } eng_state_t;

  function automatic col_t classify(input logic [7:0] ch);
    col_t c;
    unique case (ch)
      CH_A:    c = COL_A;
      CH_PLUS: c = COL_PLUS;
      CH_STAR: c = COL_STAR;
      CH_LP:   c = COL_LP;
      CH_RP:   c = COL_RP;
      CH_END:  c = COL_END;
      default: c = COL_BAD;
    endcase
    return c;
  endfunction

  // Terminal symbol that a column must match
  function automatic sym_t term_of(input col_t col);
    sym_t s;
    unique case (col)
      COL_A:    s = SY_TA;
      COL_PLUS: s = SY_PLUS;
      COL_STAR: s = SY_STAR;
      COL_LP:   s = SY_LP;
      COL_RP:   s = SY_RP;
      COL_END:  s = SY_END;
      default:  s = SY_NONE;
    endcase
    return s;
  endfunction

  // Prediction table: rows E A T B F, columns a + * ( ) $
  function automatic prod_id_t predict(input sym_t nt, input col_t col);
    prod_id_t p;
    p = P_ERR;
    unique case (nt)
      SY_E: if (col == COL_A || col == COL_LP) p = P_TA;
      SY_A: begin
        if (col == COL_PLUS) p = P_PTA;
        else if (col == COL_RP || col == COL_END) p = P_EPS;
      end
      SY_T: if (col == COL_A || col == COL_LP) p = P_FB;
      SY_B: begin
        if (col == COL_STAR) p = P_SFB;
        else if (col == COL_PLUS || col == COL_RP || col == COL_END) p = P_EPS;
      end
      SY_F: begin
        if (col == COL_A) p = P_TOK;
        else if (col == COL_LP) p = P_PAREN;
      end
      default: p = P_ERR;
    endcase
    return p;
  endfunction

  function automatic prod_t prod_of(input prod_id_t id);
    prod_t p;
    unique case (id)
      P_TA:    p = '{err: 1'b0, len: 2'd2, s0: SY_A,  s1: SY_T, s2: SY_END};
      P_PTA:   p = '{err: 1'b0, len: 2'd3, s0: SY_A,  s1: SY_T, s2: SY_PLUS};
      P_FB:    p = '{err: 1'b0, len: 2'd2, s0: SY_B,  s1: SY_F, s2: SY_END};
      P_SFB:   p = '{err: 1'b0, len: 2'd3, s0: SY_B,  s1: SY_F, s2: SY_STAR};
      P_PAREN: p = '{err: 1'b0, len: 2'd3, s0: SY_RP, s1: SY_E, s2: SY_LP};
      P_EPS:   p = '{err: 1'b0, len: 2'd0, s0: SY_END, s1: SY_END, s2: SY_END};
      P_TOK:   p = '{err: 1'b0, len: 2'd1, s0: SY_TA, s1: SY_END, s2: SY_END};
      default: p = '{err: 1'b1, len: 2'd0, s0: SY_END, s1: SY_END, s2: SY_END};
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/ll1p_front.sv
// Front end: accepts input characters, classifies them into token columns
// and holds them in a short queue for the engine. Depends on ll1p_pkg.
module ll1p_front
  import ll1p_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  output tok_t       tok,
  input  logic       tok_pop
);

  col_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  // Stall while the queue is full
  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = tok_pop && (count_r != '0);

  assign tok.valid = (count_r != '0);
  assign tok.col   = q_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store classified transaction
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= classify(in_symbol);
    end
  end

endmodule

>>> rtl/core/ll1p_engine.sv
// Back end: runs the predictive parse one expand or match step per cycle, unless a
// stalled result holds it, on the symbol stack and registers the result. Depends on ll1p_pkg.
module ll1p_engine
  import ll1p_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tok_t               tok,
  output logic               tok_pop,
  output eng_stat_t          stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_verdict,
  output logic [DEPTH_W-1:0] out_depth
);

  eng_state_t         state_r, state_nxt;
  sym_t               stack_r [STACK_DEPTH];
  sym_t               stack_nxt [STACK_DEPTH];
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic               err_r, err_nxt;
  col_t               col_r, col_nxt;
  logic               out_valid_r, out_valid_nxt;
  verdict_t           verdict_r, verdict_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  sym_t               top;
  sym_t               want;
  prod_t              pr;
  logic [SP_W:0]      new_top;
  logic               out_free;
  logic               finish;
  verdict_t           verdict;

  assign top      = stack_r[sp_r];
  assign want     = term_of(col_r);
  assign pr       = prod_of(predict(top, col_r));
  assign new_top  = {1'b0, sp_r} + (SP_W + 1)'(pr.len) - (SP_W + 1)'(1);
  assign out_free = !out_valid_r || !out_stall;

  assign stat.busy     = (state_r == ST_RUN);
  assign stat.in_error = err_r;

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_depth   = depth_r;

  // Sequence one parse step per cycle unless a stalled result holds it
  always_comb begin
    state_nxt     = state_r;
    stack_nxt     = stack_r;
    sp_nxt        = sp_r;
    err_nxt       = err_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && out_stall;
    verdict_nxt   = verdict_r;
    depth_nxt     = depth_r;
    tok_pop       = 1'b0;
    finish        = 1'b0;
    verdict       = V_CONSUMED;

    unique case (state_r)
      ST_IDLE: begin
        if (tok.valid) begin
          tok_pop   = 1'b1;
          col_nxt   = tok.col;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        priority if (err_r) begin
          finish  = 1'b1;
          verdict = V_IGNORED;
        end else if (col_r == COL_BAD) begin
          finish  = 1'b1;
          verdict = V_REJECT;
        end else if (top == SY_END) begin
          finish  = 1'b1;
          verdict = (want == SY_END) ? V_ACCEPT : V_REJECT;
        end else if (top >= SY_TA) begin
          // Match terminal on top
          finish  = 1'b1;
          verdict = (top == want) ? V_CONSUMED : V_REJECT;
        end else if (pr.err || new_top >= (SP_W + 1)'(STACK_DEPTH)) begin
          finish  = 1'b1;
          verdict = V_REJECT;
        end else begin
          // Expand nonterminal in place
          if (pr.len > 2'd0) stack_nxt[sp_r] = pr.s0;
          if (pr.len > 2'd1) stack_nxt[sp_r + SP_W'(1)] = pr.s1;
          if (pr.len > 2'd2) stack_nxt[sp_r + SP_W'(2)] = pr.s2;
          sp_nxt = new_top[SP_W-1:0];
        end

        if (finish) begin
          if (out_free) begin
            if (verdict == V_CONSUMED) begin
              sp_nxt = sp_r - 1'b1;
            end
            // Restart stack on end marker, flag errors otherwise
            if (col_r == COL_END) begin
              sp_nxt                = SP_W'(1);
              stack_nxt[SP_W'(1)]   = SY_E;
              err_nxt               = 1'b0;
            end else if (verdict == V_REJECT) begin
              err_nxt = 1'b1;
            end
            out_valid_nxt = 1'b1;
            verdict_nxt   = verdict;
            depth_nxt     = DEPTH_W'({1'b0, sp_nxt} + (SP_W + 1)'(1));
            if (tok.valid) begin
              tok_pop = 1'b1;
              col_nxt = tok.col;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // Hold until the output register frees up
            stack_nxt     = stack_r;
            sp_nxt        = sp_r;
            out_valid_nxt = out_valid_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= SP_W'(1);
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_r[i] <= (i == 1) ? SY_E : SY_END;
      end
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      stack_r     <= stack_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    verdict_r <= verdict_nxt;
    depth_r   <= depth_nxt;
  end

endmodule

>>> rtl/core/ll1_expression_parser.sv
// Top level of the LL(1) expression parser: front end with token queue and
// parse engine with output register. Depends on ll1p_pkg, ll1p_front, ll1p_engine.
//
//   channel  direction  ports                          transaction
//   input    in         in_valid in_stall in_symbol     one character byte
//   result   out        out_valid out_stall out_verdict one verdict per character
//                       out_depth
//
// An item takes one parse step per nonterminal expansion or empty pop plus
// one for the final match or verdict, so 'a' at the start of a sentence takes
// four steps, while ')' and '$' take more as they unwind A and B. A single
// engine steps the symbol stack. A token already waiting in the queue is
// taken in the cycle of the previous verdict; an idle engine first takes a
// token over from the queue in its idle state before it steps.
// Reset is synchronous and restores the stack to end marker and E. A stalled
// result holds the engine at its final step; the front keeps taking
// characters until its queue fills.
module ll1_expression_parser
  import ll1p_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_verdict,
  output logic [DEPTH_W-1:0] out_depth
);

  tok_t      tok;
  logic      tok_pop;
  eng_stat_t stat;

  ll1p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  ll1p_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok         (tok),
    .tok_pop     (tok_pop),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .out_depth   (out_depth)
  );

  // A new result only comes out of a running engine
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.busy))
    else $error("result appeared without a running parse");

  // An accepted sentence leaves a fresh stack of end marker and E
  a_accept_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == V_ACCEPT) |-> (out_depth == DEPTH_W'(2)))
    else $error("accept reported with wrong stack depth");

  // Accept never coexists with the error flag
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == V_ACCEPT) |-> !stat.in_error)
    else $error("accept reported while in error");

  // Stack never reports empty
  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth != '0))
    else $error("stack depth reported as zero");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
